// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the stack bytecode executor rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in every cycle out of reset
`define SBE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// antecedent in one cycle implies consequent in the next
`define SBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sbe_pkg.sv -----
// ---------------------------------------------------------------------------
// sbe_pkg
// shared types and constants of the stack bytecode executor
// ---------------------------------------------------------------------------
`default_nettype none

package sbe_pkg;

	// stack size and derived widths
	localparam int STACK_DEPTH = 64;
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int STACK_AW    = $clog2(STACK_DEPTH);
	localparam int WORD_W      = 64;

	// result queue
	localparam int OUTQ_DEPTH = 4;

	// config port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [0:0] REG_PRINT_ENABLE = 1'b0;

	// opcodes
	typedef enum logic [7:0] {
		OPC_HALT  = 8'h00,
		OPC_PUSH  = 8'h01,
		OPC_ADD   = 8'h02,
		OPC_MUL   = 8'h03,
		OPC_PRINT = 8'h04,
		OPC_NOP   = 8'h05
	} opcode_t;

	// operand phase: opcode expected, then operand bytes 1 to 4
	localparam logic [2:0] PHASE_OPCODE = 3'd0;
	localparam logic [2:0] PHASE_FIRST  = 3'd1;
	localparam logic [2:0] PHASE_THIRD  = 3'd3;
	localparam logic [2:0] PHASE_LAST   = 3'd4;

	// result kinds
	localparam logic KIND_PRINT = 1'b0;
	localparam logic KIND_FINAL = 1'b1;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       end_of_program;
	} in_item_t;

	typedef struct packed {
		logic                     kind;
		logic signed [WORD_W-1:0] value;
		logic                     last;
	} out_item_t;

	// up to two results per code byte, first slot filled first
	typedef struct packed {
		logic      p0_valid;
		out_item_t p0;
		logic      p1_valid;
		out_item_t p1;
	} res_push_t;

endpackage

`default_nettype wire

// ----- rtl/sbe_ram.sv -----
// ---------------------------------------------------------------------------
// sbe_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
`default_nettype none

module sbe_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/sbe_outq.sv -----
// ---------------------------------------------------------------------------
// sbe_outq
// small result queue, takes up to two results a cycle, sends one when res_ready
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sbe_outq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sbe_pkg::res_push_t  push,
	output logic                     space_ok,
	output logic                     res_valid,
	input  wire logic                res_ready,
	output sbe_pkg::out_item_t       res
);
	import sbe_pkg::*;

	localparam int PTR_W = $clog2(OUTQ_DEPTH);
	localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

	out_item_t        q_mem [OUTQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] wr_ptr_nx;
	logic [1:0]       n_wr;
	logic             pop;

	assign wr_ptr_nx = wr_ptr_q + PTR_W'(1);
	assign n_wr      = 2'(push.p0_valid) + 2'(push.p1_valid);
	assign pop       = res_valid && res_ready;
	assign res_valid = (count_q != '0);
	assign res       = q_mem[rd_ptr_q];
	assign space_ok  = (count_q <= CNT_W'(OUTQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.p0_valid) begin
			q_mem[wr_ptr_q] <= push.p0;
		end
		if (push.p1_valid) begin
			q_mem[wr_ptr_nx] <= push.p1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_wr);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(n_wr) - CNT_W'(pop);
		end
	end

	`SBE_ASSERT(a_push_order, clk, arst_n, !push.p1_valid || push.p0_valid,
		"second result slot used without the first")
	`SBE_ASSERT(a_push_room, clk, arst_n, !push.p0_valid || space_ok,
		"result pushed without room for two")

endmodule

`default_nettype wire

// ----- rtl/sbe_core.sv -----
// ---------------------------------------------------------------------------
// sbe_core
// opcode decode, stack top registers, spill ram and add/multiply datapath
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sbe_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               go,
	input  wire sbe_pkg::in_item_t  item,
	input  wire logic               print_enable,
	output sbe_pkg::res_push_t      push
);
	import sbe_pkg::*;

	// top two entries live in flops, deeper entries in the ram
	logic [DEPTH_W-1:0]  depth_q, depth_d;
	logic [2:0]          phase_q, phase_d;
	logic [23:0]         accum_q, accum_d;
	logic                finished_q, fin_d;
	logic [WORD_W-1:0]   tos_q, tos_d;
	logic [WORD_W-1:0]   nos_q, nos_d;
	logic                byp_q;
	logic [WORD_W-1:0]   byp_data_s1;

	logic                we;
	logic [STACK_AW-1:0] waddr;
	logic [STACK_AW-1:0] raddr;
	logic [DEPTH_W-1:0]  raddr_full;
	logic [WORD_W-1:0]   ram_rdata;
	logic [WORD_W-1:0]   third;
	logic [WORD_W-1:0]   push_val;
	logic [WORD_W-1:0]   alu_res;
	logic [WORD_W-1:0]   final_val;
	logic [4:0]          acc_sh;
	logic                eop;
	logic                stop;
	logic                clear;
	logic                emit_print;
	logic                emit_final;

	function automatic logic [WORD_W-1:0] mul_lo(input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b);
		logic [63:0] p_ll;
		logic [31:0] p_lh;
		logic [31:0] p_hl;
		p_ll = 64'(a[31:0]) * 64'(b[31:0]);
		p_lh = a[31:0] * b[63:32];
		p_hl = a[63:32] * b[31:0];
		return p_ll + {p_lh + p_hl, 32'b0};
	endfunction

	assign eop      = item.end_of_program;
	assign third    = byp_q ? byp_data_s1 : ram_rdata;
	assign push_val = {32'b0, item.code_byte, accum_q};
	assign alu_res  = (item.code_byte == OPC_ADD) ? (nos_q + tos_q) : mul_lo(nos_q, tos_q);
	assign acc_sh   = {phase_q[1:0] - 2'd1, 3'b000};
	assign waddr    = STACK_AW'(depth_q - DEPTH_W'(2));

	always_comb begin
		depth_d    = depth_q;
		phase_d    = phase_q;
		accum_d    = accum_q;
		fin_d      = finished_q;
		tos_d      = tos_q;
		nos_d      = nos_q;
		we         = 1'b0;
		stop       = 1'b0;
		clear      = 1'b0;
		emit_print = 1'b0;
		emit_final = 1'b0;
		final_val  = '0;
		if (go) begin
			if (finished_q) begin
				clear = eop;
			end else begin
				if (phase_q inside {[PHASE_FIRST:PHASE_THIRD]}) begin
					accum_d = accum_q | (24'(item.code_byte) << acc_sh);
					phase_d = phase_q + 3'd1;
				end else if (phase_q == PHASE_LAST) begin
					if (depth_q < DEPTH_W'(STACK_DEPTH)) begin
						we      = (depth_q >= DEPTH_W'(2));
						nos_d   = tos_q;
						tos_d   = push_val;
						depth_d = depth_q + DEPTH_W'(1);
					end
					phase_d = PHASE_OPCODE;
					accum_d = '0;
				end else begin
					phase_d = PHASE_OPCODE;
					case (item.code_byte)
						OPC_HALT: begin
							stop = 1'b1;
						end
						OPC_PUSH: begin
							if (eop || depth_q >= DEPTH_W'(STACK_DEPTH)) begin
								stop = 1'b1;
							end else begin
								phase_d = PHASE_FIRST;
								accum_d = '0;
							end
						end
						OPC_ADD, OPC_MUL: begin
							if (depth_q < DEPTH_W'(2)) begin
								stop = 1'b1;
							end else begin
								tos_d   = alu_res;
								nos_d   = third;
								depth_d = depth_q - DEPTH_W'(1);
							end
						end
						OPC_PRINT: begin
							emit_print = print_enable && (depth_q != '0);
						end
						default: begin
						end
					endcase
				end
				if (eop || stop) begin
					emit_final = 1'b1;
					final_val  = (depth_d == '0) ? '0 : tos_d;
					if (eop) begin
						clear = 1'b1;
					end else begin
						fin_d = 1'b1;
					end
				end
			end
			if (clear) begin
				depth_d = '0;
				phase_d = PHASE_OPCODE;
				accum_d = '0;
				fin_d   = 1'b0;
			end
		end
	end

	// read ahead the entry that becomes next-of-stack after a pop
	assign raddr_full = depth_d - DEPTH_W'(3);
	assign raddr      = raddr_full[STACK_AW-1:0];

	always_comb begin
		push = '0;
		if (emit_print) begin
			push.p0_valid = 1'b1;
			push.p0.kind  = KIND_PRINT;
			push.p0.value = $signed(tos_q);
			push.p0.last  = !emit_final;
			push.p1_valid = emit_final;
			push.p1.kind  = KIND_FINAL;
			push.p1.value = $signed(final_val);
			push.p1.last  = 1'b1;
		end else if (emit_final) begin
			push.p0_valid = 1'b1;
			push.p0.kind  = KIND_FINAL;
			push.p0.value = $signed(final_val);
			push.p0.last  = 1'b1;
		end
	end

	sbe_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(nos_q),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		tos_q       <= tos_d;
		nos_q       <= nos_d;
		byp_data_s1 <= nos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q    <= '0;
			phase_q    <= PHASE_OPCODE;
			accum_q    <= '0;
			finished_q <= 1'b0;
			byp_q      <= 1'b0;
		end else begin
			depth_q    <= depth_d;
			phase_q    <= phase_d;
			accum_q    <= accum_d;
			finished_q <= fin_d;
			byp_q      <= we && (waddr == raddr);
		end
	end

	`SBE_ASSERT(a_depth_range, clk, arst_n, depth_q <= DEPTH_W'(STACK_DEPTH),
		"stack depth beyond capacity")
	`SBE_ASSERT(a_phase_not_fin, clk, arst_n, (phase_q == PHASE_OPCODE) || !finished_q,
		"operand phase active after program end")
	`SBE_ASSERT_NEXT(a_eop_clears, clk, arst_n, go && eop,
		(depth_q == '0) && (phase_q == PHASE_OPCODE) && !finished_q,
		"state not cleared after last byte")

endmodule

`default_nettype wire

// ----- rtl/stack_bytecode_executor.sv -----
// ---------------------------------------------------------------------------
// stack_bytecode_executor
// runs a byte-coded stack program, one code byte per transfer
// ---------------------------------------------------------------------------
// code channel (code_valid/code_ready/code) takes one program byte per
// transfer, flagged with end_of_program on the final byte. res channel
// (res_valid/res_ready/res) returns print reports and the final result,
// with last set on the final result that a byte causes.
// a byte is registered on transfer and executed once the result queue has
// room for two results; its results are written into the result queue
// and are presented on res from there.
// throughput is one code byte per cycle while the queue has room; the
// execute stage reads the top two stack entries from flops and a read-ahead
// third entry from the spill ram; a multiply is three 32x32 products.
// a byte that yields two results needs two res transfers, so a print on
// the final byte costs one extra res transfer.
// the 4-entry result queue accepts a byte only with room for two results;
// when the receiver stalls the queue fills and code_ready drops.
// reset clears the stack depth, operand phase and end flag; the spill ram
// holds stale data but is only read below the depth, so no clearing pass.
// print_enable (apb, address 0, bit 0) resets to 1 and keeps its value
// across program ends.
// ---------------------------------------------------------------------------
`default_nettype none

module stack_bytecode_executor (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// code byte channel
	input  wire logic                         code_valid,
	output logic                              code_ready,
	input  wire sbe_pkg::in_item_t            code,
	// result channel
	output logic                              res_valid,
	input  wire logic                         res_ready,
	output sbe_pkg::out_item_t                res,
	// apb config port
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [sbe_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [sbe_pkg::PDATA_W-1:0]  pwdata,
	output logic      [sbe_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready
);
	import sbe_pkg::*;

	// input register
	in_item_t  code_s1;
	logic      valid_s1;

	logic      print_enable_q;
	logic      go;
	logic      space_ok;
	logic      reg_sel;
	res_push_t push;

	// execute when the queue has room for the worst case of two results
	assign go         = valid_s1 && space_ok;
	assign code_ready = !valid_s1 || go;

	always_ff @(posedge clk) begin
		if (code_valid && code_ready) begin
			code_s1 <= code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (code_ready) begin
			valid_s1 <= code_valid;
		end
	end

	// config register, word address decode only
	assign reg_sel = (paddr[2] == REG_PRINT_ENABLE);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? {{(PDATA_W-1){1'b0}}, print_enable_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			print_enable_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			print_enable_q <= pwdata[0];
		end
	end

	// execute stage and stack
	sbe_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (go),
		.item        (code_s1),
		.print_enable(print_enable_q),
		.push        (push)
	);

	// result queue
	sbe_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space_ok (space_ok),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

endmodule

`default_nettype wire
